### design/fca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fca_pkg
// Shared sizes, codes and types of the file allocation table engine.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int NUM_ENTRIES     = 64;
  localparam int NUM_BLOCKS      = 1024;
  localparam int RESERVED_BLOCKS = 16;

  localparam int ENTRY_W = $clog2(NUM_ENTRIES);
  localparam int BLOCK_W = $clog2(NUM_BLOCKS);
  localparam int TABLE_W = BLOCK_W + 1;      // next block or end-of-chain mark
  localparam int NAME_W  = 64;
  localparam int COUNT_W = 11;               // block_count port
  localparam int STAT_W  = 3;
  localparam int CNT_W   = (BLOCK_W + 1 > COUNT_W) ? BLOCK_W + 1 : COUNT_W;

  localparam logic [TABLE_W-1:0] CHAIN_END = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_NO_INODE  = 3'd2,
    ST_NO_BLOCKS = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    ACT_CREATE = 1'b0,
    ACT_FIND   = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAPS,
    S_COUNT,
    S_LINK,
    S_TAIL,
    S_COMMIT,
    S_FIND,
    S_F_INO,
    S_F_LATCH,
    S_F_START,
    S_F_DONE
  } state_e;

  // table write beat
  typedef struct packed {
    logic               en;
    logic [BLOCK_W-1:0] addr;
    logic [TABLE_W-1:0] data;
  } tbl_wr_t;

endpackage
`default_nettype wire

### design/fat_chain_file_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_file_allocator_unit
// File allocation table engine: create a file with a block chain, or find
// a file by its name tag.
// ----------------------------------------------------------------------------
// After reset the block sweeps all NUM_BLOCKS (1024) table entries to zero
// with busy high. A beat is taken when start is high and busy is
// low; busy then stays high until the result, which shows for one cycle
// with done_o and cannot be held off. A create scans the slot and inode
// maps, then counts free table blocks with one table read per cycle, then,
// for a nonzero count with enough free blocks, walks the table again to
// link the chain; both table passes share the single table read port. A
// find reads one directory name per cycle. A failed create leaves every
// table and map untouched and returns zero fields.
// ----------------------------------------------------------------------------
module fat_chain_file_allocator_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic [fca_pkg::NAME_W-1:0]     name_tag_i,
  input  logic [fca_pkg::COUNT_W-1:0]    block_count_i,
  output logic                           done_o,
  output logic [fca_pkg::STAT_W-1:0]     status_o,
  output logic [fca_pkg::ENTRY_W-1:0]    dir_slot_o,
  output logic [fca_pkg::ENTRY_W-1:0]    inode_index_o,
  output logic                           has_blocks_o,
  output logic [fca_pkg::BLOCK_W-1:0]    start_block_o
);

  localparam int EW = fca_pkg::ENTRY_W;
  localparam int BW = fca_pkg::BLOCK_W;
  localparam int TW = fca_pkg::TABLE_W;
  localparam int CW = fca_pkg::CNT_W;

  fca_pkg::state_e state_q, state_d;

  // captured request
  logic [fca_pkg::NAME_W-1:0]    name_q, name_d;
  logic [CW-1:0]                 count_q, count_d;

  // scan control
  logic [EW:0]   idx_q, idx_d;
  logic [EW-1:0] pidx_q, pidx_d;
  logic [BW:0]   addr_q, addr_d;
  logic [BW-1:0] paddr_q, paddr_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] free_cnt_q, free_cnt_d;
  logic [CW-1:0] taken_q, taken_d;
  logic [BW-1:0] prev_q, prev_d;
  logic [BW-1:0] start_q, start_d;
  logic [EW-1:0] slot_q, slot_d;
  logic [EW-1:0] ino_q, ino_d;
  logic          slot_found_q, slot_found_d;
  logic          ino_found_q, ino_found_d;

  // result
  logic          done_q, done_d;
  logic [fca_pkg::STAT_W-1:0] status_q, status_d;
  logic [EW-1:0] rslot_q, rslot_d;
  logic [EW-1:0] rino_q, rino_d;
  logic          rhas_q, rhas_d;
  logic [BW-1:0] rstart_q, rstart_d;

  // maps and directory stores
  logic [fca_pkg::NUM_ENTRIES-1:0] dir_used_q, inode_used_q;
  logic [fca_pkg::NAME_W-1:0] dir_names_mem [fca_pkg::NUM_ENTRIES];
  logic [EW-1:0]              dir_inode_mem [fca_pkg::NUM_ENTRIES];
  logic [TW-1:0]              inode_start_mem [fca_pkg::NUM_ENTRIES];
  logic [fca_pkg::NAME_W-1:0] names_rd_q;
  logic [EW-1:0]              ino_rd_q;
  logic [TW-1:0]              inost_rd_q;
  logic                       commit;
  logic [TW-1:0]              commit_start;

  // table
  fca_pkg::tbl_wr_t tbl_wr;
  logic             tbl_free;
  logic             issue_blk, issue_ent, hit, has_c;

  fca_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .rd_addr_i (addr_q[BW-1:0]),
    .rd_free_o (tbl_free)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fca_pkg::S_CLEAR;
      addr_q       <= '0;
      pend_q       <= 1'b0;
      done_q       <= 1'b0;
      dir_used_q   <= '0;
      inode_used_q <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      if (commit) begin
        dir_used_q[slot_q]  <= 1'b1;
        inode_used_q[ino_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    name_q       <= name_d;
    count_q      <= count_d;
    idx_q        <= idx_d;
    pidx_q       <= pidx_d;
    paddr_q      <= paddr_d;
    free_cnt_q   <= free_cnt_d;
    taken_q      <= taken_d;
    prev_q       <= prev_d;
    start_q      <= start_d;
    slot_q       <= slot_d;
    ino_q        <= ino_d;
    slot_found_q <= slot_found_d;
    ino_found_q  <= ino_found_d;
    status_q     <= status_d;
    rslot_q      <= rslot_d;
    rino_q       <= rino_d;
    rhas_q       <= rhas_d;
    rstart_q     <= rstart_d;
  end

  // directory stores: one write beat on commit, reads always registered
  always_ff @(posedge clk_i) begin
    if (commit) begin
      dir_names_mem[slot_q]  <= name_q;
      dir_inode_mem[slot_q]  <= ino_q;
      inode_start_mem[ino_q] <= commit_start;
    end
    names_rd_q <= dir_names_mem[idx_q[EW-1:0]];
    ino_rd_q   <= dir_inode_mem[slot_q];
    inost_rd_q <= inode_start_mem[ino_q];
  end

  assign has_c        = (count_q != '0);
  assign commit_start = has_c ? TW'(start_q) : fca_pkg::CHAIN_END;
  assign issue_blk    = (addr_q < (BW+1)'(fca_pkg::NUM_BLOCKS));
  assign issue_ent    = (idx_q < (EW+1)'(fca_pkg::NUM_ENTRIES));
  assign hit          = pend_q && dir_used_q[pidx_q] && (names_rd_q == name_q);

  always_comb begin
    state_d      = state_q;
    name_d       = name_q;
    count_d      = count_q;
    idx_d        = idx_q;
    pidx_d       = pidx_q;
    addr_d       = addr_q;
    paddr_d      = paddr_q;
    pend_d       = pend_q;
    free_cnt_d   = free_cnt_q;
    taken_d      = taken_q;
    prev_d       = prev_q;
    start_d      = start_q;
    slot_d       = slot_q;
    ino_d        = ino_q;
    slot_found_d = slot_found_q;
    ino_found_d  = ino_found_q;
    done_d       = 1'b0;
    status_d     = status_q;
    rslot_d      = rslot_q;
    rino_d       = rino_q;
    rhas_d       = rhas_q;
    rstart_d     = rstart_q;
    commit       = 1'b0;
    tbl_wr       = '0;

    case (state_q)
      fca_pkg::S_CLEAR: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = addr_q[BW-1:0];
        addr_d      = addr_q + 1'b1;
        if (addr_q == (BW+1)'(fca_pkg::NUM_BLOCKS - 1)) begin
          state_d = fca_pkg::S_IDLE;
        end
      end

      fca_pkg::S_IDLE: begin
        if (start) begin
          name_d       = name_tag_i;
          count_d      = CW'(block_count_i);
          idx_d        = '0;
          pend_d       = 1'b0;
          slot_found_d = 1'b0;
          ino_found_d  = 1'b0;
          state_d      = (action_i == fca_pkg::ACT_FIND) ? fca_pkg::S_FIND : fca_pkg::S_MAPS;
        end
      end

      // lowest free slot and inode, one entry a cycle
      fca_pkg::S_MAPS: begin
        idx_d = idx_q + 1'b1;
        if (!slot_found_q && !dir_used_q[idx_q[EW-1:0]]) begin
          slot_d       = idx_q[EW-1:0];
          slot_found_d = 1'b1;
        end
        if (!ino_found_q && !inode_used_q[idx_q[EW-1:0]]) begin
          ino_d       = idx_q[EW-1:0];
          ino_found_d = 1'b1;
        end
        if (idx_q == (EW+1)'(fca_pkg::NUM_ENTRIES - 1)) begin
          if (!slot_found_d) begin
            done_d   = 1'b1;
            status_d = fca_pkg::ST_NO_SLOT;
            rslot_d  = '0;
            rino_d   = '0;
            rhas_d   = 1'b0;
            rstart_d = '0;
            state_d  = fca_pkg::S_IDLE;
          end else if (!ino_found_d) begin
            done_d   = 1'b1;
            status_d = fca_pkg::ST_NO_INODE;
            rslot_d  = '0;
            rino_d   = '0;
            rhas_d   = 1'b0;
            rstart_d = '0;
            state_d  = fca_pkg::S_IDLE;
          end else begin
            addr_d     = (BW+1)'(fca_pkg::RESERVED_BLOCKS);
            pend_d     = 1'b0;
            free_cnt_d = '0;
            state_d    = fca_pkg::S_COUNT;
          end
        end
      end

      // count free blocks, pipelined reads
      fca_pkg::S_COUNT: begin
        pend_d  = issue_blk;
        paddr_d = addr_q[BW-1:0];
        if (issue_blk) begin
          addr_d = addr_q + 1'b1;
        end
        if (pend_q && tbl_free) begin
          free_cnt_d = free_cnt_q + 1'b1;
        end
        if (!issue_blk && !pend_q) begin
          if (count_q > free_cnt_q) begin
            done_d   = 1'b1;
            status_d = fca_pkg::ST_NO_BLOCKS;
            rslot_d  = '0;
            rino_d   = '0;
            rhas_d   = 1'b0;
            rstart_d = '0;
            state_d  = fca_pkg::S_IDLE;
          end else if (!has_c) begin
            state_d = fca_pkg::S_COMMIT;
          end else begin
            addr_d  = (BW+1)'(fca_pkg::RESERVED_BLOCKS);
            pend_d  = 1'b0;
            taken_d = '0;
            state_d = fca_pkg::S_LINK;
          end
        end
      end

      // link free blocks: each found block is written into its predecessor
      fca_pkg::S_LINK: begin
        pend_d  = issue_blk;
        paddr_d = addr_q[BW-1:0];
        if (issue_blk) begin
          addr_d = addr_q + 1'b1;
        end
        if (taken_q == count_q) begin
          state_d = fca_pkg::S_TAIL;
        end else if (pend_q && tbl_free) begin
          if (taken_q == '0) begin
            start_d = paddr_q;
          end else begin
            tbl_wr.en   = 1'b1;
            tbl_wr.addr = prev_q;
            tbl_wr.data = TW'(paddr_q);
          end
          prev_d  = paddr_q;
          taken_d = taken_q + 1'b1;
        end
      end

      fca_pkg::S_TAIL: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = prev_q;
        tbl_wr.data = fca_pkg::CHAIN_END;
        state_d     = fca_pkg::S_COMMIT;
      end

      fca_pkg::S_COMMIT: begin
        commit   = 1'b1;
        done_d   = 1'b1;
        status_d = fca_pkg::ST_OK;
        rslot_d  = slot_q;
        rino_d   = ino_q;
        rhas_d   = has_c;
        rstart_d = has_c ? start_q : '0;
        state_d  = fca_pkg::S_IDLE;
      end

      // name search, one directory read per cycle
      fca_pkg::S_FIND: begin
        pend_d = issue_ent;
        pidx_d = idx_q[EW-1:0];
        if (issue_ent) begin
          idx_d = idx_q + 1'b1;
        end
        if (hit) begin
          slot_d  = pidx_q;
          state_d = fca_pkg::S_F_INO;
        end else if (!issue_ent && !pend_q) begin
          done_d   = 1'b1;
          status_d = fca_pkg::ST_NOT_FOUND;
          rslot_d  = '0;
          rino_d   = '0;
          rhas_d   = 1'b0;
          rstart_d = '0;
          state_d  = fca_pkg::S_IDLE;
        end
      end

      fca_pkg::S_F_INO: begin
        state_d = fca_pkg::S_F_LATCH;
      end

      fca_pkg::S_F_LATCH: begin
        ino_d   = ino_rd_q;
        state_d = fca_pkg::S_F_START;
      end

      fca_pkg::S_F_START: begin
        state_d = fca_pkg::S_F_DONE;
      end

      fca_pkg::S_F_DONE: begin
        done_d   = 1'b1;
        status_d = fca_pkg::ST_OK;
        rslot_d  = slot_q;
        rino_d   = ino_q;
        rhas_d   = (inost_rd_q != fca_pkg::CHAIN_END);
        rstart_d = (inost_rd_q != fca_pkg::CHAIN_END) ? inost_rd_q[BW-1:0] : '0;
        state_d  = fca_pkg::S_IDLE;
      end

      default: begin
        state_d = fca_pkg::S_IDLE;
      end
    endcase
  end

  assign busy          = (state_q != fca_pkg::S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign dir_slot_o    = rslot_q;
  assign inode_index_o = rino_q;
  assign has_blocks_o  = rhas_q;
  assign start_block_o = rstart_q;

  // a result always lands with the engine idle again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result while busy");

  // failed results carry zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != fca_pkg::ST_OK) |->
      (dir_slot_o == '0 && inode_index_o == '0 && !has_blocks_o))
    else $error("nonzero fields on failure");

  // no chain means start block zero
  a_no_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_blocks_o) |-> (start_block_o == '0))
    else $error("start block without chain");

  // an accepted beat makes the engine busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("beat not taken");

  // the link pass never takes more blocks than asked
  a_link_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fca_pkg::S_LINK) |-> (taken_q <= count_q))
    else $error("chain overrun");

endmodule
`default_nettype wire

### design/fca_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fca_table
// Allocation table memory: one write and one registered read per cycle,
// with a free test on the read data.
// ----------------------------------------------------------------------------
module fca_table (
  input  logic                          clk_i,
  input  fca_pkg::tbl_wr_t              wr_i,
  input  logic [fca_pkg::BLOCK_W-1:0]   rd_addr_i,
  output logic                          rd_free_o
);

  logic [fca_pkg::TABLE_W-1:0] mem [fca_pkg::NUM_BLOCKS];
  logic [fca_pkg::TABLE_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_free_o = (rd_q == '0);

endmodule
`default_nettype wire

### test/fat_chain_file_allocator_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fat_chain_file_allocator_unit_tb
// Self-checking bench for the file allocation table engine. An in-bench
// model of the table, directory and inode maps predicts every result;
// directed tests cover the corner cases, then random create/find traffic
// runs under several sender idle rates.
// ----------------------------------------------------------------------------
module fat_chain_file_allocator_unit_tb;

  localparam int WD_LIMIT = 20000;  // cycles with no beat and no result

  localparam int ENTRY_W = fca_pkg::ENTRY_W;
  localparam int BLOCK_W = fca_pkg::BLOCK_W;
  localparam int TABLE_W = fca_pkg::TABLE_W;
  localparam int NAME_W  = fca_pkg::NAME_W;
  localparam int COUNT_W = fca_pkg::COUNT_W;
  localparam int STAT_W  = fca_pkg::STAT_W;

  typedef struct packed {
    fca_pkg::status_e   status;
    logic [ENTRY_W-1:0] slot;
    logic [ENTRY_W-1:0] inode;
    logic               has_blk;
    logic [BLOCK_W-1:0] first_blk;
  } file_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                action_i;
  logic [NAME_W-1:0]   name_tag_i;
  logic [COUNT_W-1:0]  block_count_i;
  logic                done_o;
  logic [STAT_W-1:0]   status_o;
  logic [ENTRY_W-1:0]  dir_slot_o;
  logic [ENTRY_W-1:0]  inode_index_o;
  logic                has_blocks_o;
  logic [BLOCK_W-1:0]  start_block_o;

  fat_chain_file_allocator_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .name_tag_i    (name_tag_i),
    .block_count_i (block_count_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .dir_slot_o    (dir_slot_o),
    .inode_index_o (inode_index_o),
    .has_blocks_o  (has_blocks_o),
    .start_block_o (start_block_o)
  );

  // Shadow copy of the engine state
  logic [TABLE_W-1:0] fat_q      [fca_pkg::NUM_BLOCKS];
  logic [NAME_W-1:0]  slot_name  [fca_pkg::NUM_ENTRIES];
  logic               slot_used  [fca_pkg::NUM_ENTRIES];
  logic [ENTRY_W-1:0] slot_inode [fca_pkg::NUM_ENTRIES];
  logic               inode_busy [fca_pkg::NUM_ENTRIES];
  logic [TABLE_W-1:0] inode_head [fca_pkg::NUM_ENTRIES];

  file_res_t         pending_q[$];   // results still owed by the engine
  logic [NAME_W-1:0] names_made[$];  // tags of created files, for finds
  bit                failed;
  int                idle_pct;
  int                quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Free blocks above the reserved area
  function automatic int free_blocks();
    int n;
    n = 0;
    for (int b = fca_pkg::RESERVED_BLOCKS; b < fca_pkg::NUM_BLOCKS; b++)
      if (fat_q[b] == '0) n++;
    return n;
  endfunction

  // Apply one beat to the shadow state and return the expected result.
  function automatic file_res_t fat_apply(fca_pkg::action_e act, logic [NAME_W-1:0] nm,
                                          logic [COUNT_W-1:0] cnt);
    file_res_t r;
    int s, ino, taken, prev;
    logic [TABLE_W-1:0] head;
    r = '0;
    r.status = fca_pkg::ST_OK;
    head = fca_pkg::CHAIN_END;
    if (act == fca_pkg::ACT_FIND) begin
      for (s = 0; s < fca_pkg::NUM_ENTRIES; s++)
        if (slot_used[s] && slot_name[s] == nm) break;
      if (s >= fca_pkg::NUM_ENTRIES) begin
        r.status = fca_pkg::ST_NOT_FOUND;
        return r;
      end
      r.slot  = ENTRY_W'(s);
      r.inode = slot_inode[s];
      head    = inode_head[slot_inode[s]];
    end else begin
      for (s = 0; s < fca_pkg::NUM_ENTRIES; s++) if (!slot_used[s]) break;
      if (s >= fca_pkg::NUM_ENTRIES) begin
        r.status = fca_pkg::ST_NO_SLOT;
        return r;
      end
      for (ino = 0; ino < fca_pkg::NUM_ENTRIES; ino++) if (!inode_busy[ino]) break;
      if (ino >= fca_pkg::NUM_ENTRIES) begin
        r.status = fca_pkg::ST_NO_INODE;
        return r;
      end
      if (int'(cnt) > free_blocks()) begin
        r.status = fca_pkg::ST_NO_BLOCKS;
        return r;
      end
      // link the chain upward from the first block after the reserved area
      taken = 0;
      prev  = 0;
      for (int b = fca_pkg::RESERVED_BLOCKS;
           b < fca_pkg::NUM_BLOCKS && taken < int'(cnt); b++) begin
        if (fat_q[b] != '0) continue;
        if (taken == 0) head = TABLE_W'(b);
        else fat_q[prev] = TABLE_W'(b);
        fat_q[b] = fca_pkg::CHAIN_END;
        prev = b;
        taken++;
      end
      slot_used[s]     = 1'b1;
      slot_name[s]     = nm;
      slot_inode[s]    = ENTRY_W'(ino);
      inode_busy[ino]  = 1'b1;
      inode_head[ino]  = head;
      r.slot  = ENTRY_W'(s);
      r.inode = ENTRY_W'(ino);
      names_made.push_back(nm);
    end
    if (head != fca_pkg::CHAIN_END) begin
      r.has_blk   = 1'b1;
      r.first_blk = head[BLOCK_W-1:0];
    end
    return r;
  endfunction

  // Send one beat: start stays high until taken, then gets an optional gap.
  task automatic send_beat(fca_pkg::action_e act, logic [NAME_W-1:0] nm,
                           logic [COUNT_W-1:0] cnt);
    int gap;
    start         <= 1'b1;
    action_i      <= act;
    name_tag_i    <= nm;
    block_count_i <= cnt;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(fat_apply(act, nm, cnt));
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait for the engine to drain before a new phase.
  task automatic drain();
    wait (pending_q.size() == 0);
    @(posedge clk_i);
  endtask

  // Result checker: the engine cannot be held off, so every strobe counts.
  always @(posedge clk_i) begin
    file_res_t got, want;
    if (rst_ni && done_o) begin
      got = {status_o, dir_slot_o, inode_index_o, has_blocks_o, start_block_o};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected st=%0d slot=%0d ino=%0d has=%0d blk=%0d",
                   $time, want.status, want.slot, want.inode, want.has_blk,
                   want.first_blk);
          $display("%0t:          actual   st=%0d slot=%0d ino=%0d has=%0d blk=%0d",
                   $time, status_o, dir_slot_o, inode_index_o, has_blocks_o,
                   start_block_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: a create may walk the whole table twice, plus the reset sweep.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("[fat_chain_file_allocator_unit] ERROR");
      $finish;
    end
  end

  // --- directed tests -------------------------------------------------------

  // Find on an empty directory, and a zero-length create before any block use.
  task automatic test_empty_and_zero();
    send_beat(fca_pkg::ACT_FIND, '0, '0);
    send_beat(fca_pkg::ACT_FIND, '1, 11'h7ff);
    send_beat(fca_pkg::ACT_CREATE, '0, '0);          // zero length: no chain
    send_beat(fca_pkg::ACT_FIND, '0, 11'd5);         // block count ignored on find
  endtask

  // Oversized lengths fail and leave no trace.
  task automatic test_oversize();
    send_beat(fca_pkg::ACT_CREATE, 64'h0123_4567_89ab_cdef, 11'h7ff);
    send_beat(fca_pkg::ACT_CREATE, 64'h0123_4567_89ab_cdef, 11'd1024);
    send_beat(fca_pkg::ACT_CREATE, 64'h0123_4567_89ab_cdef, 11'(free_blocks() + 1));
    send_beat(fca_pkg::ACT_FIND, 64'h0123_4567_89ab_cdef, '0);
  endtask

  // Short chains, extreme tags, duplicates and finds of each.
  task automatic test_chains();
    send_beat(fca_pkg::ACT_CREATE, '1, 11'd1);
    send_beat(fca_pkg::ACT_CREATE, 64'h8000_0000_0000_0001, 11'd3);
    send_beat(fca_pkg::ACT_CREATE, '1, 11'd2);       // duplicate tag
    send_beat(fca_pkg::ACT_CREATE, 64'h5555_aaaa_5555_aaaa, 11'd17);
    send_beat(fca_pkg::ACT_FIND, '1, '0);            // lowest slot wins
    send_beat(fca_pkg::ACT_FIND, 64'h8000_0000_0000_0001, '0);
    send_beat(fca_pkg::ACT_FIND, 64'h5555_aaaa_5555_aaaa, 11'h7ff);
    send_beat(fca_pkg::ACT_FIND, 64'hdead_beef_0000_0000, '0);
  endtask

  // --- random traffic -------------------------------------------------------
  task automatic test_random(int beats, int pct);
    logic [NAME_W-1:0]  nm;
    logic [COUNT_W-1:0] cnt;
    int pick;
    idle_pct = pct;
    for (int i = 0; i < beats; i++) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 30 && names_made.size() > 0)
        nm = names_made[$urandom_range(names_made.size() - 1)];
      else
        nm = {$urandom, $urandom};
      if (pick < 45) begin
        send_beat(fca_pkg::ACT_FIND, nm, 11'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 65)      cnt = COUNT_W'($urandom_range(0, 8));
        else if (pick < 85) cnt = COUNT_W'($urandom_range(9, 60));
        else if (pick < 90) cnt = COUNT_W'(free_blocks());       // exact fit
        else if (pick < 93) cnt = COUNT_W'(free_blocks() + 1);   // one short
        else                cnt = COUNT_W'($urandom_range(0, 2047));
        send_beat(fca_pkg::ACT_CREATE, nm, cnt);
      end
    end
    start <= 1'b0;
    drain();
  endtask

  initial begin
    failed        = 1'b0;
    idle_pct      = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = fca_pkg::ACT_CREATE;
    name_tag_i    = '0;
    block_count_i = '0;
    for (int b = 0; b < fca_pkg::NUM_BLOCKS; b++) fat_q[b] = '0;
    for (int e = 0; e < fca_pkg::NUM_ENTRIES; e++) begin
      slot_name[e]  = '0;
      slot_used[e]  = 1'b0;
      slot_inode[e] = '0;
      inode_busy[e] = 1'b0;
      inode_head[e] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_zero();
    test_oversize();
    test_chains();
    start <= 1'b0;
    drain();

    test_random(70, 0);
    test_random(75, 67);
    test_random(75, 38);
    test_random(70, 67);

    repeat (20) @(posedge clk_i);
    if (!failed && pending_q.size() == 0)
      $display("[fat_chain_file_allocator_unit] OK");
    else
      $display("[fat_chain_file_allocator_unit] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

### fat_chain_file_allocator_unit.f
design/fca_pkg.sv
design/fca_table.sv
design/fat_chain_file_allocator_unit.sv
test/fat_chain_file_allocator_unit_tb.sv
